>>> rtl/kplc_pkg.sv
// Package: shared types and constants for the keypad PIN lock controller.
`timescale 1ns / 1ps

package kplc_pkg;

	localparam int unsigned TICK_W  = 16;
	localparam int unsigned LIMIT_W = 3;
	localparam int unsigned KEY_W   = 4;
	localparam int unsigned FIELD_W = 3;
	localparam int unsigned CIDX_W  = 3;

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_OPEN_TICKS    = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_WINDOW_TICKS  = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_WRONG_TICKS   = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_LOCKOUT_TICKS = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_CHANGED_TICKS = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_ATTEMPT_LIMIT = 3'd5;

	localparam logic [TICK_W-1:0]  RST_OPEN_TICKS    = 16'd3000;
	localparam logic [TICK_W-1:0]  RST_WINDOW_TICKS  = 16'd3000;
	localparam logic [TICK_W-1:0]  RST_WRONG_TICKS   = 16'd2000;
	localparam logic [TICK_W-1:0]  RST_LOCKOUT_TICKS = 16'd5000;
	localparam logic [TICK_W-1:0]  RST_CHANGED_TICKS = 16'd2000;
	localparam logic [LIMIT_W-1:0] RST_ATTEMPT_LIMIT = 3'd3;

	localparam logic [KEY_W-1:0] KEY_MAX_DIGIT = 4'd9;
	localparam logic [KEY_W-1:0] KEY_HASH      = 4'd11;

	localparam logic KIND_KEY  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef enum logic [2:0] {
		M_ENTER   = 3'd0,
		M_OPEN    = 3'd1,
		M_WINDOW  = 3'd2,
		M_NEWPIN  = 3'd3,
		M_WRONG   = 3'd4,
		M_LOCK    = 3'd5,
		M_CHANGED = 3'd6
	} mode_t;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_DIGIT   = 3'd1,
		EV_GRANT   = 3'd2,
		EV_WRONG   = 3'd3,
		EV_LOCKED  = 3'd4,
		EV_CHSTART = 3'd5,
		EV_CHANGED = 3'd6
	} event_t;

	typedef struct packed {
		logic [TICK_W-1:0]  open_ticks;
		logic [TICK_W-1:0]  window_ticks;
		logic [TICK_W-1:0]  wrong_ticks;
		logic [TICK_W-1:0]  lockout_ticks;
		logic [TICK_W-1:0]  changed_ticks;
		logic [LIMIT_W-1:0] attempt_limit;
	} cfg_t;

	typedef struct packed {
		mode_t              mode;
		logic [FIELD_W-1:0] digits;
		logic [FIELD_W-1:0] fails;
		event_t             evt;
	} status_t;

endpackage

>>> rtl/keypad_pin_lock_controller.sv
// Top level of the keypad PIN lock controller: handshakes, input stage, result stage.
`timescale 1ns / 1ps

//  channel | valid / ready          | payload
//  --------+------------------------+------------------------------------------------
//  in      | in_valid / in_ready    | kind, key_code
//  out     | out_valid / out_ready  | relay_on, mode, digits_entered, event_res,
//          |                        | failed_count
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data (cfg_ready is always high)
//
// One transaction per cycle sustained while out_ready is high: an input is captured
// into the _s1 stage, then the state update and result are computed and registered
// once the result slot is free. A stalled result holds the _s1 stage; in_ready
// falls only when both the _s1 stage and the result register are occupied and
// out_ready is low. Reset restores the default timing registers, PIN 1234, mode
// enter and clears all counters; no clearing pass is needed.

module keypad_pin_lock_controller #(
	parameter int unsigned PIN_DIGITS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// key / tick input
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [kplc_pkg::KEY_W-1:0]    key_code,
	// result output
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          relay_on,
	output logic [kplc_pkg::FIELD_W-1:0]  mode,
	output logic [kplc_pkg::FIELD_W-1:0]  digits_entered,
	output logic [kplc_pkg::FIELD_W-1:0]  event_res,
	output logic [kplc_pkg::FIELD_W-1:0]  failed_count,
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kplc_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [kplc_pkg::TICK_W-1:0]   cfg_data
);
	import kplc_pkg::*;

	logic             valid_s1;
	logic             kind_s1;
	logic [KEY_W-1:0] key_s1;
	logic             out_valid_q;
	logic             advance;
	cfg_t             cfg;
	status_t          status;

	// item in _s1 moves into the state / result registers when the result slot frees
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= kind;
			key_s1  <= key_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign cfg_ready = 1'b1;

	kplc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// State registers change only on advance, so they also serve as the result register.
	kplc_fsm #(
		.PIN_DIGITS (PIN_DIGITS)
	) u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.kind    (kind_s1),
		.key     (key_s1),
		.cfg     (cfg),
		.status  (status)
	);

	assign out_valid      = out_valid_q;
	assign relay_on       = (status.mode == M_OPEN);
	assign mode           = status.mode;
	assign digits_entered = status.digits;
	assign event_res      = status.evt;
	assign failed_count   = status.fails;

	// a lockout always leaves the failure count cleared
	a_lock_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_LOCKED |-> failed_count == '0 && mode == M_LOCK)
		else $error("lockout without cleared failure count");

	// a completed entry always leaves the digit count at zero
	a_entry_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == EV_GRANT || event_res == EV_WRONG ||
		event_res == EV_CHANGED) |-> digits_entered == '0)
		else $error("digit count not reset after completed entry");

	// a stalled result must not change under the consumer
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(mode))
		else $error("result changed while stalled");

	// digits are only taken in entry modes
	a_digit_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_DIGIT |-> mode == M_ENTER || mode == M_NEWPIN)
		else $error("digit taken outside an entry mode");

endmodule

>>> rtl/kplc_cfg_regs.sv
// Configuration register file for the keypad PIN lock controller.
`timescale 1ns / 1ps

module kplc_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [kplc_pkg::CIDX_W-1:0]  wr_index,
	input  logic [kplc_pkg::TICK_W-1:0]  wr_data,
	output kplc_pkg::cfg_t               cfg
);
	import kplc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_ticks    <= RST_OPEN_TICKS;
			cfg_q.window_ticks  <= RST_WINDOW_TICKS;
			cfg_q.wrong_ticks   <= RST_WRONG_TICKS;
			cfg_q.lockout_ticks <= RST_LOCKOUT_TICKS;
			cfg_q.changed_ticks <= RST_CHANGED_TICKS;
			cfg_q.attempt_limit <= RST_ATTEMPT_LIMIT;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_OPEN_TICKS:    cfg_q.open_ticks    <= wr_data;
				CFG_WINDOW_TICKS:  cfg_q.window_ticks  <= wr_data;
				CFG_WRONG_TICKS:   cfg_q.wrong_ticks   <= wr_data;
				CFG_LOCKOUT_TICKS: cfg_q.lockout_ticks <= wr_data;
				CFG_CHANGED_TICKS: cfg_q.changed_ticks <= wr_data;
				CFG_ATTEMPT_LIMIT: cfg_q.attempt_limit <= wr_data[LIMIT_W-1:0];
				default: begin
					// unmapped index: write dropped
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/kplc_fsm.sv
// Lock state machine: entry store, PIN store, hold timer and failure counter.
`timescale 1ns / 1ps

module kplc_fsm #(
	parameter int unsigned PIN_DIGITS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step_en,
	input  logic                        kind,
	input  logic [kplc_pkg::KEY_W-1:0]  key,
	input  kplc_pkg::cfg_t              cfg,
	output kplc_pkg::status_t           status
);
	import kplc_pkg::*;

	localparam int unsigned CW = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;
	localparam logic [CW-1:0] LAST_IDX = CW'(PIN_DIGITS - 1);

	mode_t                mode_q, mode_d;
	logic [CW-1:0]        cnt_q, cnt_d;
	logic [LIMIT_W-1:0]   fail_q, fail_d;
	logic [TICK_W-1:0]    timer_q, timer_d;
	event_t               evt_q, evt_d;
	logic [KEY_W-1:0]     entry_q [PIN_DIGITS];
	logic [KEY_W-1:0]     pin_q   [PIN_DIGITS];
	logic [KEY_W-1:0]     full_entry [PIN_DIGITS];
	logic                 take, pin_we, is_digit, last, match;

	assign is_digit = (key <= KEY_MAX_DIGIT);
	assign last     = (cnt_q == LAST_IDX);

	// Completed entry: stored digits with the final slot taken from the current key
	always_comb begin
		match = 1'b1;
		for (int i = 0; i < PIN_DIGITS; i++) begin
			full_entry[i] = (CW'(i) == LAST_IDX) ? key : entry_q[i];
			if (full_entry[i] != pin_q[i])
				match = 1'b0;
		end
	end

	always_comb begin
		mode_d  = mode_q;
		cnt_d   = cnt_q;
		fail_d  = fail_q;
		timer_d = timer_q;
		evt_d   = EV_NONE;
		take    = 1'b0;
		pin_we  = 1'b0;
		if (kind == KIND_TICK) begin
			unique case (mode_q)
				M_ENTER, M_NEWPIN: begin
					// untimed modes
				end
				M_OPEN, M_WINDOW, M_WRONG, M_LOCK, M_CHANGED: begin
					if (timer_q > TICK_W'(1)) begin
						timer_d = timer_q - TICK_W'(1);
					end else if (mode_q == M_OPEN) begin
						mode_d  = M_WINDOW;
						timer_d = cfg.window_ticks;
					end else begin
						mode_d  = M_ENTER;
						timer_d = '0;
						cnt_d   = '0;
					end
				end
				default: mode_d = M_ENTER;
			endcase
		end else begin
			unique case (mode_q)
				M_WINDOW: begin
					if (key == KEY_HASH) begin
						mode_d = M_NEWPIN;
						cnt_d  = '0;
						evt_d  = EV_CHSTART;
					end
				end
				M_NEWPIN: begin
					if (is_digit) begin
						take = 1'b1;
						if (last) begin
							cnt_d   = '0;
							pin_we  = 1'b1;
							mode_d  = M_CHANGED;
							timer_d = cfg.changed_ticks;
							evt_d   = EV_CHANGED;
						end else begin
							cnt_d = cnt_q + CW'(1);
							evt_d = EV_DIGIT;
						end
					end
				end
				M_OPEN, M_WRONG, M_LOCK, M_CHANGED: begin
					// keys ignored during holds
				end
				default: begin
					mode_d = M_ENTER;
					if (is_digit) begin
						take = 1'b1;
						if (!last) begin
							cnt_d = cnt_q + CW'(1);
							evt_d = EV_DIGIT;
						end else begin
							cnt_d = '0;
							if (match) begin
								fail_d  = '0;
								mode_d  = M_OPEN;
								timer_d = cfg.open_ticks;
								evt_d   = EV_GRANT;
							end else if ((fail_q + LIMIT_W'(1)) >= cfg.attempt_limit) begin
								fail_d  = '0;
								mode_d  = M_LOCK;
								timer_d = cfg.lockout_ticks;
								evt_d   = EV_LOCKED;
							end else begin
								fail_d  = fail_q + LIMIT_W'(1);
								mode_d  = M_WRONG;
								timer_d = cfg.wrong_ticks;
								evt_d   = EV_WRONG;
							end
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_ENTER;
			cnt_q   <= '0;
			fail_q  <= '0;
			timer_q <= '0;
			evt_q   <= EV_NONE;
		end else if (step_en) begin
			mode_q  <= mode_d;
			cnt_q   <= cnt_d;
			fail_q  <= fail_d;
			timer_q <= timer_d;
			evt_q   <= evt_d;
		end
	end

	// entry digits: no reset, only read once fully written
	always_ff @(posedge clk) begin
		for (int i = 0; i < PIN_DIGITS; i++) begin
			if (step_en && take && (CW'(i) == cnt_q))
				entry_q[i] <= key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIN_DIGITS; i++)
				pin_q[i] <= KEY_W'((i + 1) % 10);
		end else if (step_en && pin_we) begin
			for (int i = 0; i < PIN_DIGITS; i++)
				pin_q[i] <= full_entry[i];
		end
	end

	assign status.mode   = mode_q;
	assign status.digits = FIELD_W'(cnt_q);
	assign status.fails  = fail_q;
	assign status.evt    = evt_q;

endmodule

>>> verif/tb.sv
// Testbench for the keypad PIN lock controller: stimulus, status prediction and checking.
`timescale 1ns / 1ps

// Keys and ticks are planned ahead against a shadow copy of the lock, so that
// most random traffic is well-formed PIN entries with random content. The
// planned transactions sit in a queue that a clocked driver drains at the
// falling edge. At each rising edge a monitor tracks the lock on every accepted
// input or config transaction, queues the status it expects, and compares each
// accepted result with the oldest queued status.
module tb;
	import kplc_pkg::*;

	localparam int NDIG      = 4;
	localparam int LIMIT     = 300000;  // cycles; slowest legal run is well under this
	localparam int MAX_SHOWN = 10;

	// unused register indexes, written to check they are ignored
	localparam logic [CIDX_W-1:0] CFG_UNUSED_LO = 3'd6;
	localparam logic [CIDX_W-1:0] CFG_UNUSED_HI = 3'd7;

	localparam logic [KEY_W-1:0] KEY_STAR = 4'd10;
	localparam logic [KEY_W-1:0] KEY_TOP  = 4'd15;

	typedef enum logic {
		JOB_KEY,
		JOB_CFG
	} job_kind_t;

	// one pending transaction for the driver
	typedef struct packed {
		job_kind_t          op;
		logic               kind;
		logic [KEY_W-1:0]   key;
		logic [CIDX_W-1:0]  idx;
		logic [TICK_W-1:0]  data;
	} key_job_t;

	// lock state as seen from outside, plus the event of the last step
	typedef struct packed {
		mode_t                   mode;
		logic [NDIG-1:0][3:0]    entry;
		logic [NDIG-1:0][3:0]    pin;
		logic [2:0]              cnt;
		logic [2:0]              fails;
		logic [TICK_W-1:0]       timer;
		event_t                  ev;
		cfg_t                    cfg;
	} lock_state_t;

	typedef struct packed {
		logic       relay;
		logic [2:0] mode;
		logic [2:0] digits;
		logic [2:0] evt;
		logic [2:0] fails;
	} lock_status_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 kind;
	logic [KEY_W-1:0]     key_code;
	logic                 out_valid;
	logic                 out_ready;
	logic                 relay_on;
	logic [FIELD_W-1:0]   mode;
	logic [FIELD_W-1:0]   digits_entered;
	logic [FIELD_W-1:0]   event_res;
	logic [FIELD_W-1:0]   failed_count;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CIDX_W-1:0]    cfg_index;
	logic [TICK_W-1:0]    cfg_data;

	key_job_t      key_jobs[$];
	lock_status_t  status_due[$];
	lock_state_t   plan_st;   // advanced as transactions are planned
	lock_state_t   seen_st;   // advanced as transactions are accepted

	int  cycles;
	int  quiet;
	int  got_cnt;
	int  err_cnt;
	bit  in_took;
	bit  cfg_took;

	int  tx_gap, tx_burst;
	int  rx_gap, rx_burst, rx_hold;
	bit  hold_done;

	keypad_pin_lock_controller #(.PIN_DIGITS(NDIG)) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.key_code       (key_code),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.relay_on       (relay_on),
		.mode           (mode),
		.digits_entered (digits_entered),
		.event_res      (event_res),
		.failed_count   (failed_count),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// ------------------------------------------------------------------
	// Lock behavior
	// ------------------------------------------------------------------

	function automatic lock_state_t lock_reset();
		lock_state_t s;
		s = '0;
		s.mode = M_ENTER;
		s.ev   = EV_NONE;
		for (int i = 0; i < NDIG; i++)
			s.pin[i] = 4'((i + 1) % 10);
		s.cfg.open_ticks    = RST_OPEN_TICKS;
		s.cfg.window_ticks  = RST_WINDOW_TICKS;
		s.cfg.wrong_ticks   = RST_WRONG_TICKS;
		s.cfg.lockout_ticks = RST_LOCKOUT_TICKS;
		s.cfg.changed_ticks = RST_CHANGED_TICKS;
		s.cfg.attempt_limit = RST_ATTEMPT_LIMIT;
		return s;
	endfunction

	// Register write; data is cut to the register width, unknown indexes do nothing.
	function automatic cfg_t cfg_write(cfg_t c, logic [CIDX_W-1:0] idx, logic [TICK_W-1:0] d);
		case (idx)
			CFG_OPEN_TICKS:    c.open_ticks    = d;
			CFG_WINDOW_TICKS:  c.window_ticks  = d;
			CFG_WRONG_TICKS:   c.wrong_ticks   = d;
			CFG_LOCKOUT_TICKS: c.lockout_ticks = d;
			CFG_CHANGED_TICKS: c.changed_ticks = d;
			CFG_ATTEMPT_LIMIT: c.attempt_limit = d[LIMIT_W-1:0];
			default: ;
		endcase
		return c;
	endfunction

	// Stores one digit; the count wraps to zero when the entry is complete.
	function automatic lock_state_t put_digit(lock_state_t s, logic [3:0] d);
		logic [2:0] idx;
		idx = (s.cnt >= NDIG) ? 3'd0 : s.cnt;
		s.entry[idx] = d;
		idx = idx + 3'd1;
		s.cnt = (idx >= NDIG) ? 3'd0 : idx;
		return s;
	endfunction

	function automatic lock_state_t lock_step(lock_state_t s, logic k, logic [KEY_W-1:0] key);
		s.ev = EV_NONE;
		if (k == KIND_KEY) begin
			case (s.mode)
				M_WINDOW: begin
					if (key == KEY_HASH) begin
						s.mode = M_NEWPIN;
						s.cnt  = 3'd0;
						s.ev   = EV_CHSTART;
					end
				end
				M_NEWPIN: begin
					if (key <= KEY_MAX_DIGIT) begin
						s = put_digit(s, key);
						if (s.cnt != 3'd0) begin
							s.ev = EV_DIGIT;
						end else begin
							s.pin   = s.entry;
							s.mode  = M_CHANGED;
							s.timer = s.cfg.changed_ticks;
							s.ev    = EV_CHANGED;
						end
					end
				end
				M_OPEN, M_WRONG, M_LOCK, M_CHANGED: ;
				default: begin
					s.mode = M_ENTER;
					if (key <= KEY_MAX_DIGIT) begin
						s = put_digit(s, key);
						if (s.cnt != 3'd0) begin
							s.ev = EV_DIGIT;
						end else if (s.entry == s.pin) begin
							s.fails = 3'd0;
							s.mode  = M_OPEN;
							s.timer = s.cfg.open_ticks;
							s.ev    = EV_GRANT;
						end else begin
							s.fails = s.fails + 3'd1;
							if (s.fails >= s.cfg.attempt_limit) begin
								// limit of zero lands here on every failure
								s.fails = 3'd0;
								s.mode  = M_LOCK;
								s.timer = s.cfg.lockout_ticks;
								s.ev    = EV_LOCKED;
							end else begin
								s.mode  = M_WRONG;
								s.timer = s.cfg.wrong_ticks;
								s.ev    = EV_WRONG;
							end
						end
					end
				end
			endcase
		end else if (s.mode != M_ENTER && s.mode != M_NEWPIN) begin
			// timed modes: a loaded zero ends on the first tick, same as one
			if (s.timer > 16'd1) begin
				s.timer = s.timer - 16'd1;
			end else if (s.mode == M_OPEN) begin
				s.mode  = M_WINDOW;
				s.timer = s.cfg.window_ticks;
			end else begin
				s.timer = 16'd0;
				s.mode  = M_ENTER;
				s.cnt   = 3'd0;
			end
		end
		return s;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// ------------------------------------------------------------------
	// Planning
	// ------------------------------------------------------------------

	task automatic push_key(logic k, logic [KEY_W-1:0] key);
		key_jobs.push_back('{op: JOB_KEY, kind: k, key: key, idx: '0, data: '0});
		plan_st = lock_step(plan_st, k, key);
	endtask

	task automatic push_tick();
		push_key(KIND_TICK, 4'($urandom_range(0, 15)));
	endtask

	task automatic push_cfg(logic [CIDX_W-1:0] idx, logic [TICK_W-1:0] d);
		key_jobs.push_back('{op: JOB_CFG, kind: KIND_KEY, key: '0, idx: idx, data: d});
		plan_st.cfg = cfg_write(plan_st.cfg, idx, d);
	endtask

	task automatic type_code(logic [NDIG-1:0][3:0] code);
		for (int i = 0; i < NDIG; i++)
			push_key(KIND_KEY, code[i]);
	endtask

	task automatic configure(int o, int w, int wr, int lk, int ch, int lim);
		push_cfg(CFG_OPEN_TICKS,    16'(o));
		push_cfg(CFG_WINDOW_TICKS,  16'(w));
		push_cfg(CFG_WRONG_TICKS,   16'(wr));
		push_cfg(CFG_LOCKOUT_TICKS, 16'(lk));
		push_cfg(CFG_CHANGED_TICKS, 16'(ch));
		push_cfg(CFG_ATTEMPT_LIMIT, 16'(lim));
	endtask

	// Random traffic shaped by the planned mode: mostly entries with the right
	// PIN or random digits, ticks in timed modes, hash in the change window.
	task automatic random_traffic(int n);
		int start;
		int r;
		logic [NDIG-1:0][3:0] code;
		start = key_jobs.size();
		while (key_jobs.size() - start < n) begin
			r = $urandom_range(0, 99);
			case (plan_st.mode)
				M_ENTER: begin
					if (plan_st.cnt == 3'd0 && r < 45) begin
						type_code(plan_st.pin);
					end else if (r < 70) begin
						push_key(KIND_KEY, 4'($urandom_range(0, 9)));
					end else if (r < 80) begin
						for (int i = 0; i < NDIG; i++)
							code[i] = 4'($urandom_range(0, 9));
						type_code(code);
					end else if (r < 90) begin
						push_tick();
					end else begin
						push_key(KIND_KEY, 4'($urandom_range(10, 15)));
					end
				end
				M_NEWPIN: begin
					if (r < 80)
						push_key(KIND_KEY, 4'($urandom_range(0, 9)));
					else if (r < 90)
						push_tick();
					else
						push_key(KIND_KEY, 4'($urandom_range(10, 15)));
				end
				M_WINDOW: begin
					if (r < 40)
						push_key(KIND_KEY, KEY_HASH);
					else if (r < 75)
						push_tick();
					else
						push_key(KIND_KEY, 4'($urandom_range(0, 15)));
				end
				default: begin
					if (r < 80)
						push_tick();
					else
						push_key(KIND_KEY, 4'($urandom_range(0, 15)));
				end
			endcase
		end
	endtask

	// ------------------------------------------------------------------
	// Clock, reset, stimulus plan and end of run
	// ------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		kind      = KIND_KEY;
		key_code  = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		plan_st   = lock_reset();
		seen_st   = lock_reset();

		// short timers for the directed part; limit data has high bits set
		// that the 3-bit register must drop (0xFFFA -> 2)
		configure(2, 3, 1, 0, 2, 16'hFFFA);
		push_cfg(CFG_UNUSED_LO, 16'h0000);
		push_cfg(CFG_UNUSED_HI, 16'hFFFF);

		push_key(KIND_KEY, KEY_STAR);      // non-digit keys while collecting
		push_key(KIND_KEY, KEY_HASH);
		push_key(KIND_KEY, KEY_TOP);
		type_code(plan_st.pin);            // reset PIN -> granted, relay on
		push_key(KIND_KEY, 4'd5);          // key while open: ignored
		push_tick();
		push_tick();                       // open ends in the change window
		push_key(KIND_KEY, KEY_HASH);      // start PIN change
		type_code({4'd0, 4'd9, 4'd0, 4'd9});
		push_tick();
		push_tick();                       // changed hold over
		type_code({4'd4, 4'd3, 4'd2, 4'd1}); // old PIN now wrong
		push_tick();                       // wrong hold of one tick
		push_tick();                       // tick in enter changes nothing
		type_code({4'd8, 4'd9, 4'd0, 4'd9}); // second failure -> lockout
		push_tick();                       // lockout loaded with zero ends at once

		configure(3, 4, 2, 3, 2, 3);
		random_traffic(150);
		configure(1, 1, 1, 1, 1, 1);
		random_traffic(60);
		// limit of zero: every failure locks out
		configure($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
			$urandom_range(0, 3), $urandom_range(0, 3), 0);
		random_traffic(60);
		configure($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4),
			$urandom_range(1, 4), $urandom_range(1, 4), 7);
		random_traffic(100);
		configure($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6),
			$urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 7));
		random_traffic(60);
		// widest timers last, since a mode loaded with them never ends here
		configure(65535, 65535, 65535, 65535, 65535, 16'hFFFF);
		random_traffic(25);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (key_jobs.size() != 0 || in_valid || cfg_valid || status_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);   // room for a stray late result

		if (err_cnt == 0 && status_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin : watchdog
		while (cycles < LIMIT)
			@(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Driver: input and config channels, changes on the falling edge
	// ------------------------------------------------------------------

	always @(negedge clk) begin : driver
		logic nv;
		logic ncv;
		nv  = in_valid;
		ncv = cfg_valid;
		if (in_took)
			nv = 1'b0;
		if (cfg_took)
			ncv = 1'b0;
		if (arst_n && !nv && !ncv) begin
			if (tx_gap > 0) begin
				tx_gap--;
			end else if (key_jobs.size() != 0) begin
				if (key_jobs[0].op == JOB_KEY) begin
					nv = 1'b1;
					kind     <= key_jobs[0].kind;
					key_code <= key_jobs[0].key;
					void'(key_jobs.pop_front());
					if (tx_burst > 0) begin
						tx_burst--;
					end else begin
						tx_gap = gap_len();
						if ($urandom_range(0, 40) == 0)
							tx_burst = $urandom_range(20, 60);
					end
				end else if (status_due.size() == 0 && quiet >= 3) begin
					// register writes only once the two-stage pipe has drained
					ncv = 1'b1;
					cfg_index <= key_jobs[0].idx;
					cfg_data  <= key_jobs[0].data;
					void'(key_jobs.pop_front());
				end
			end
		end
		in_valid  <= nv;
		cfg_valid <= ncv;
	end

	// ------------------------------------------------------------------
	// Result side back-pressure: random stalls, one long hold-off early on
	// so that the pipe fills and in_ready drops while items keep coming
	// ------------------------------------------------------------------

	always @(negedge clk) begin
		if (!hold_done && got_cnt >= 120) begin
			hold_done = 1'b1;
			rx_hold   = 100;
		end
		if (rx_hold > 0) begin
			rx_hold--;
			out_ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (rx_burst > 0) begin
				rx_burst--;
			end else begin
				rx_gap = gap_len();
				if ($urandom_range(0, 40) == 0)
					rx_burst = $urandom_range(20, 60);
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: tracks accepted transactions and checks results
	// ------------------------------------------------------------------

	always @(posedge clk) begin : monitor
		lock_status_t got;
		lock_status_t want;
		cycles++;
		in_took  = arst_n && in_valid && in_ready;
		cfg_took = arst_n && cfg_valid && cfg_ready;

		// check before queueing: a result can't come from this edge's input
		if (arst_n && out_valid && out_ready) begin
			got_cnt++;
			got = '{relay: relay_on, mode: mode, digits: digits_entered,
				evt: event_res, fails: failed_count};
			if (status_due.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_SHOWN)
					$display("unexpected result relay=%0d mode=%0d digits=%0d event=%0d fails=%0d",
						got.relay, got.mode, got.digits, got.evt, got.fails);
			end else begin
				want = status_due.pop_front();
				if (got.relay !== want.relay || got.mode !== want.mode ||
						got.digits !== want.digits || got.evt !== want.evt ||
						got.fails !== want.fails) begin
					err_cnt++;
					if (err_cnt <= MAX_SHOWN)
						$display("result %0d: want relay=%0d mode=%0d digits=%0d event=%0d fails=%0d, got relay=%0d mode=%0d digits=%0d event=%0d fails=%0d",
							got_cnt, want.relay, want.mode, want.digits, want.evt, want.fails,
							got.relay, got.mode, got.digits, got.evt, got.fails);
				end
			end
		end

		if (cfg_took)
			seen_st.cfg = cfg_write(seen_st.cfg, cfg_index, cfg_data);
		if (in_took) begin
			seen_st = lock_step(seen_st, kind, key_code);
			status_due.push_back('{relay: seen_st.mode == M_OPEN, mode: seen_st.mode,
				digits: seen_st.cnt, evt: seen_st.ev, fails: seen_st.fails});
		end

		if (status_due.size() == 0 && !in_valid)
			quiet++;
		else
			quiet = 0;
	end

endmodule

>>> sim.f
rtl/kplc_pkg.sv
rtl/kplc_cfg_regs.sv
rtl/kplc_fsm.sv
rtl/keypad_pin_lock_controller.sv
verif/tb.sv
